@@ sv/irsm_pkg.sv @@
package irsm_pkg;
	localparam int unsigned RULES_DEF = 8;
	localparam int unsigned W = 32;
	localparam logic [1:0] MODE_REL = 2'd0;
	localparam logic [1:0] MODE_SGN = 2'd1;
	localparam logic [1:0] MODE_UNS = 2'd2;
	localparam logic [0:0] FUNC_QUERY = 1'b0;
	localparam logic [0:0] FUNC_WRITE = 1'b1;
	localparam logic [0:0] CFG_RULE_COUNT = 1'b0;
	localparam logic [0:0] CFG_COMPARE_MODE = 1'b1;
	localparam int unsigned F_INV = 0;
	localparam int unsigned F_SPAN = 1;
	localparam int unsigned F_LOW_END = 2;
	localparam int unsigned F_LOW_NONE = 3;
	localparam int unsigned F_HIGH_END = 4;
	localparam int unsigned F_HIGH_NONE = 5;
	localparam int unsigned ENTRY_W = 6 + 4 * W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_MOD,
		ST_DONE
	} state_t;

	// bound evaluation result handed to the step unit
	typedef struct packed {
		logic       skip;
		logic       range_ok;
		logic       need_step;
		logic       inv;
	} eval_t;
endpackage

@@ sv/irsm_ram.sv @@
module irsm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ sv/irsm_mod.sv @@
// restoring unsigned remainder, one bit a cycle; flags zero remainder
module irsm_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [irsm_pkg::W-1:0]    dividend,
	input  logic [irsm_pkg::W-1:0]    divisor,
	output logic                      done,
	output logic                      zero
);
	localparam int unsigned CW = $clog2(irsm_pkg::W);

	logic [irsm_pkg::W-1:0] num_q, den_q, rem_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic [irsm_pkg::W:0]   trial;
	logic [irsm_pkg::W:0]   diff;

	assign trial = {rem_q, num_q[irsm_pkg::W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(irsm_pkg::W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[irsm_pkg::W-2:0], 1'b0};
			rem_q <= diff[irsm_pkg::W] ? trial[irsm_pkg::W-1:0] : diff[irsm_pkg::W-1:0];
		end
	end

	assign zero = (rem_q == '0);
endmodule

@@ sv/irsm_eval.sv @@
// bound test of one rule
module irsm_eval (
	input  logic [5:0]              flags,
	input  logic [irsm_pkg::W-1:0]  lo,
	input  logic [irsm_pkg::W-1:0]  hi,
	input  logic [irsm_pkg::W-1:0]  step,
	input  logic [irsm_pkg::W-1:0]  m,
	input  logic [irsm_pkg::W-1:0]  last,
	input  logic [1:0]              mode,
	output irsm_pkg::eval_t         res
);
	logic [irsm_pkg::W-1:0] x, y;
	logic loinf, hiinf, skip, ge, le, single, span, inv;

	assign span = flags[irsm_pkg::F_SPAN];
	assign inv  = flags[irsm_pkg::F_INV];

	always_comb begin
		x = lo;
		y = hi;
		loinf = 1'b0;
		hiinf = 1'b0;
		skip = 1'b0;
		ge = 1'b0;
		le = 1'b0;
		case (mode)
			irsm_pkg::MODE_SGN: begin
				if (flags[irsm_pkg::F_LOW_NONE]) loinf = 1'b1;
				else if (flags[irsm_pkg::F_LOW_END]) begin
					if (lo == '0) loinf = 1'b1; else x = '0 - lo;
				end
				if (flags[irsm_pkg::F_HIGH_NONE]) hiinf = 1'b1;
				else if (flags[irsm_pkg::F_HIGH_END]) begin
					if (hi == '0) hiinf = 1'b1; else y = '0 - hi;
				end
				ge = $signed(m) >= $signed(x);
				le = $signed(m) <= $signed(y);
			end
			irsm_pkg::MODE_UNS: begin
				loinf = flags[irsm_pkg::F_LOW_END] | flags[irsm_pkg::F_LOW_NONE];
				hiinf = flags[irsm_pkg::F_HIGH_END] | flags[irsm_pkg::F_HIGH_NONE];
				ge = m >= x;
				le = m <= y;
			end
			default: begin
				if (flags[irsm_pkg::F_LOW_END]) begin
					if (lo == '0) loinf = 1'b1;
					else x = (last < lo) ? '0 : last - lo;
				end else if (flags[irsm_pkg::F_LOW_NONE]) loinf = 1'b1;
				if (flags[irsm_pkg::F_HIGH_NONE]) hiinf = 1'b1;
				else if (flags[irsm_pkg::F_HIGH_END]) begin
					if (last < hi && !inv) skip = 1'b1;
					if (hi == '0) hiinf = 1'b1; else y = last - hi;
				end
				ge = m >= x;
				le = m <= y;
			end
		endcase
		single = (m == x) && !loinf;
	end

	always_comb begin
		res.inv = inv;
		if (!span) begin
			res.skip = 1'b0;
			res.range_ok = single;
			res.need_step = 1'b0;
		end else begin
			res.skip = skip;
			res.range_ok = (loinf || ge) && (hiinf || le);
			res.need_step = (step > irsm_pkg::W'(1));
		end
	end
endmodule

@@ sv/index_range_set_matcher.sv @@
// Range-rule matcher.
// s_axis carries items: write items (func=1) load one rule into the rule
// RAM and give no result; query items (func=0) give one hit on m_axis.
// Rule count and compare mode are set through cfg_we/cfg_index/cfg_data;
// the user must set them only while the block is idle, which the block
// itself does not enforce. A write leaves the block idle; the next item
// can follow right behind it. A query walks the rules one at a time, each
// through a RAM read and a bound test, plus a bit-serial remainder for a
// span rule with step >= 2 that passes the bound test, stopping at the first
// hit. The query ends in the done state, which sets the output valid; an
// empty table goes there straight from the query transfer.
// The hit waits in an output register; the next item is taken the cycle
// after it is transferred. Stalling m_axis_tready holds the result and
// s_axis_tready low.
// Reset clears control, configuration and output registers; rule RAM content is undefined
// until written, so queries must only touch written rules.
module index_range_set_matcher #(
	parameter int unsigned RULES = irsm_pkg::RULES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [0] func [3:1] rule_slot [9:4] rule_bits [41:10] rule_low
	// [73:42] rule_high [105:74] rule_step [137:106] rule_offset
	// [169:138] probe_index [201:170] last_position, pad to 208
	input  logic [207:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [0] hit
	output logic [7:0]   m_axis_tdata,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [3:0]   cfg_data
);
	localparam int unsigned AW = (RULES > 1) ? $clog2(RULES) : 1;
	localparam int unsigned W = irsm_pkg::W;
	localparam int unsigned EW = irsm_pkg::ENTRY_W;

	logic [3:0] rule_count_q;
	logic [1:0] mode_q;
	irsm_pkg::state_t state_q, state_d;
	logic [AW:0] k_q, k_d;
	logic [AW:0] n_lim;
	logic [W-1:0] m_q, last_q;
	logic hit_q, out_v_q;

	logic        func;
	logic [2:0]  slot;
	logic        we;
	logic [EW-1:0] wdata, rdata;
	logic [5:0]  r_flags;
	logic [W-1:0] r_lo, r_hi, r_step, r_off;
	irsm_pkg::eval_t ev, ev_s2;
	logic [W-1:0] step_s2, off_s2;
	logic mod_start, mod_done, mod_zero;
	logic accept, rule_true, last_rule;

	assign func = s_axis_tdata[0];
	assign slot = s_axis_tdata[3:1];
	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == irsm_pkg::ST_IDLE) && !out_v_q;
	assign we = accept && (func == irsm_pkg::FUNC_WRITE) && (32'(slot) < RULES);
	assign wdata = {s_axis_tdata[137:106], s_axis_tdata[105:74],
		s_axis_tdata[73:42], s_axis_tdata[41:10], s_axis_tdata[9:4]};
	assign {r_off, r_step, r_hi, r_lo, r_flags} = rdata;
	assign n_lim = (32'(rule_count_q) > RULES) ? (AW+1)'(RULES) : (AW+1)'(rule_count_q);

	// rule index of the next cycle; the RAM reads it so data is ready in ST_READ
	always_comb begin
		k_d = k_q;
		if (accept)
			k_d = '0;
		else if (state_d == irsm_pkg::ST_READ && state_q != irsm_pkg::ST_IDLE)
			k_d = k_q + 1'b1;
	end

	irsm_ram #(.WIDTH(EW), .DEPTH(RULES)) u_rules (
		.clk(clk), .we(we), .waddr(AW'(slot)), .wdata(wdata),
		.raddr(k_d[AW-1:0]), .rdata(rdata)
	);

	irsm_eval u_eval (
		.flags(r_flags), .lo(r_lo), .hi(r_hi), .step(r_step),
		.m(m_q), .last(last_q), .mode(mode_q), .res(ev)
	);

	irsm_mod u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start),
		.dividend(m_q + off_s2), .divisor(step_s2),
		.done(mod_done), .zero(mod_zero)
	);

	assign mod_start = (state_q == irsm_pkg::ST_EVAL) && !ev_s2.skip &&
		ev_s2.range_ok && ev_s2.need_step;
	assign last_rule = (k_q + 1'b1) >= n_lim;

	always_comb begin
		rule_true = 1'b0;
		if (state_q == irsm_pkg::ST_EVAL && !ev_s2.skip && !mod_start)
			rule_true = ev_s2.range_ok ^ ev_s2.inv;
		else if (state_q == irsm_pkg::ST_MOD && mod_done)
			rule_true = mod_zero ^ ev_s2.inv;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			irsm_pkg::ST_IDLE:
				if (accept && func == irsm_pkg::FUNC_QUERY)
					state_d = (n_lim == '0) ? irsm_pkg::ST_DONE : irsm_pkg::ST_READ;
			irsm_pkg::ST_READ: state_d = irsm_pkg::ST_EVAL;
			irsm_pkg::ST_EVAL:
				if (mod_start) state_d = irsm_pkg::ST_MOD;
				else if (rule_true || last_rule) state_d = irsm_pkg::ST_DONE;
				else state_d = irsm_pkg::ST_READ;
			irsm_pkg::ST_MOD:
				if (mod_done) begin
					if (rule_true || last_rule) state_d = irsm_pkg::ST_DONE;
					else state_d = irsm_pkg::ST_READ;
				end
			irsm_pkg::ST_DONE: state_d = irsm_pkg::ST_IDLE;
			default: state_d = irsm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irsm_pkg::ST_IDLE;
			rule_count_q <= '0;
			mode_q <= irsm_pkg::MODE_REL;
			k_q <= '0;
			hit_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q <= k_d;
			if (cfg_we) begin
				if (cfg_index == irsm_pkg::CFG_RULE_COUNT) rule_count_q <= cfg_data;
				else mode_q <= (cfg_data[1:0] == 2'd3) ? irsm_pkg::MODE_REL : cfg_data[1:0];
			end
			if (accept)
				hit_q <= (n_lim == '0);
			else if (rule_true)
				hit_q <= 1'b1;
			if (state_q == irsm_pkg::ST_DONE) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_q <= s_axis_tdata[169:138];
			last_q <= s_axis_tdata[201:170];
		end
		// stage 2 captures the bound test of the rule just read
		if (state_q == irsm_pkg::ST_READ) begin
			ev_s2 <= ev;
			step_s2 <= r_step;
			off_s2 <= r_off;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {7'b0, hit_q};

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != irsm_pkg::ST_IDLE) |-> !s_axis_tready)
		else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(hit_q)))
		else $error("result dropped");
	a_mod_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> ($past(state_q) == irsm_pkg::ST_MOD))
		else $error("remainder done outside step test");
`endif
endmodule
